// File: rtl/core/fpba_pkg.sv
// Shared types, field layout and codes of the fenced page bump allocator.
package fpba_pkg;

   // Parameter defaults
   localparam int NUM_PAGES_DEF      = 64;
   localparam int MAX_PAGE_BYTES_DEF = 2097152;
   localparam int FENCE_BITS_DEF     = 64;

   // Field widths on the ports
   localparam int SIZE_W     = 22;
   localparam int ALIGN_W    = 5;
   localparam int FENCE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int PAGE_IDX_W = 6;
   localparam int OFFSET_W   = 21;

   // Request tdata layout, lowest bit first
   localparam int IN_SIZE_LSB  = 0;
   localparam int IN_ALIGN_LSB = IN_SIZE_LSB + SIZE_W;
   localparam int IN_FENCE_LSB = IN_ALIGN_LSB + ALIGN_W;
   localparam int IN_DONE_LSB  = IN_FENCE_LSB + FENCE_W;
   localparam int IN_USED_W    = IN_DONE_LSB + FENCE_W;
   localparam int REQ_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit first
   localparam int OUT_PAGE_LSB  = 0;
   localparam int OUT_OFF_LSB   = OUT_PAGE_LSB + PAGE_IDX_W;
   localparam int OUT_SIZE_LSB  = OUT_OFF_LSB + OFFSET_W;
   localparam int OUT_TOOK_LSB  = OUT_SIZE_LSB + SIZE_W;
   localparam int OUT_USED_W    = OUT_TOOK_LSB + 1;
   localparam int RSP_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

   // Page size after reset
   localparam int PAGE_SIZE_RESET = 65536;

   // Width for alignment arithmetic: 22-bit value plus a mask of up to 31 bits
   localparam int WIDE_W = 33;

   typedef enum logic [0:0] {
      OP_ALLOC  = 1'b0,
      OP_RETIRE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TOO_BIG = 2'd1,
      STATUS_NO_PAGE = 2'd2
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;       // latch request and aligned values
      logic ok_held;      // answer from the held page
      logic push_held;    // move held page to the local list
      logic ret_rd;       // read retired queue head
      logic recycle;      // retired head goes to the free FIFO
      logic free_rd;      // read free FIFO head
      logic take_free;    // hold the page read from the free FIFO
      logic take_new;     // hold a freshly made page
      logic no_page;      // answer pool exhausted
      logic too_big;      // answer oversized request
      logic loc_rd;       // read local list entry
      logic ret_push;     // push local entry to the retired queue
      logic retire_done;  // clear local list, answer retire
   } fpba_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic op_retire;
      logic too_big;
      logic fits;
      logic held_valid;
      logic ret_nonempty;
      logic fence_done;
      logic free_nonempty;
      logic can_make;
      logic loc_more;
      logic rsp_free;
   } fpba_stat_type;

endpackage

// File: rtl/core/fenced_page_bump_allocator.sv
// Fenced page bump allocator, top level: controller, datapath and result register.
//
// Hands out byte ranges from fixed-size pages by bumping a fill offset, with
// power-of-two alignment of both the size and the offset. An allocation that
// fits the held page is accepted and aligned, and then checked for the fit and
// loaded into the result register. When a new page is needed, the controller
// first walks the retired queue head, one retired page at a time, until the
// queue runs empty or its head's fence is not yet done, and then takes a page
// from the free FIFO or makes a new one; each read of a queue memory waits on
// its registered read port. A retire request reads each page on the local
// list from the local list memory and writes it to the retired queue. The
// result sits in an output register, so the next request is accepted while a
// result waits to be taken. The queue memories need no clearing after reset,
// so requests are taken at once. Writes to the page size register are taken
// at any time but must be made while no request is in flight.
module fenced_page_bump_allocator
   import fpba_pkg::*;
#(
   parameter int NUM_PAGES      = NUM_PAGES_DEF,
   parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF,
   parameter int FENCE_BITS     = FENCE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // operation
   // size_bytes[21:0], align_log2[26:22], fence_value[90:27], completed_fence[154:91]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STATUS_W-1:0]   rsp_tuser,   // status
   // page_index[5:0], offset[26:6], aligned_size[48:27], took_new_page[49]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Page size register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_W-1:0]     csr_data
);

   fpba_cmd_type  cmd;
   fpba_stat_type stat;

   assign csr_ready = 1'b1;

   // Sequencing
   fpba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Page state, queues and result register
   fpba_datapath #(
      .NUM_PAGES      (NUM_PAGES),
      .MAX_PAGE_BYTES (MAX_PAGE_BYTES),
      .FENCE_BITS     (FENCE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/core/fpba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fpba_ctrl.sv
// Controller state machine of the fenced page bump allocator.
module fpba_ctrl
   import fpba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  fpba_stat_type stat,
   output fpba_cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DECIDE    = 9'b000000010,
      ST_RC_READ   = 9'b000000100,
      ST_RC_CHECK  = 9'b000001000,
      ST_OBTAIN    = 9'b000010000,
      ST_FREE_WAIT = 9'b000100000,
      ST_RT_READ   = 9'b001000000,
      ST_RT_PUSH   = 9'b010000000,
      ST_RT_DONE   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (stat.op_retire) begin
               cmd.push_held = stat.held_valid;
               state_in      = ST_RT_READ;
            end else if (stat.too_big) begin
               if (stat.rsp_free) begin
                  cmd.too_big = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (stat.fits) begin
               if (stat.rsp_free) begin
                  cmd.ok_held = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.push_held = stat.held_valid;
               state_in      = ST_RC_READ;
            end
         end
         ST_RC_READ: begin
            if (stat.ret_nonempty) begin
               cmd.ret_rd = 1'b1;
               state_in   = ST_RC_CHECK;
            end else begin
               state_in = ST_OBTAIN;
            end
         end
         ST_RC_CHECK: begin
            if (stat.fence_done) begin
               cmd.recycle = 1'b1;
               state_in    = ST_RC_READ;
            end else begin
               state_in = ST_OBTAIN;
            end
         end
         ST_OBTAIN: begin
            priority if (stat.free_nonempty) begin
               cmd.free_rd = 1'b1;
               state_in    = ST_FREE_WAIT;
            end else if (stat.rsp_free) begin
               cmd.take_new = stat.can_make;
               cmd.no_page  = !stat.can_make;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_OBTAIN;
            end
         end
         ST_FREE_WAIT: begin
            if (stat.rsp_free) begin
               cmd.take_free = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_RT_READ: begin
            if (stat.loc_more) begin
               cmd.loc_rd = 1'b1;
               state_in   = ST_RT_PUSH;
            end else begin
               state_in = ST_RT_DONE;
            end
         end
         ST_RT_PUSH: begin
            cmd.ret_push = 1'b1;
            state_in     = ST_RT_READ;
         end
         ST_RT_DONE: begin
            if (stat.rsp_free) begin
               cmd.retire_done = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/fpba_datapath.sv
// Datapath of the fenced page bump allocator: page state, queues and result register.
module fpba_datapath
   import fpba_pkg::*;
#(
   parameter int NUM_PAGES      = NUM_PAGES_DEF,
   parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF,
   parameter int FENCE_BITS     = FENCE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic [SIZE_W-1:0]     csr_data,
   input  fpba_cmd_type          cmd,
   output fpba_stat_type         stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PAGE_W = $clog2(NUM_PAGES);
   localparam int CNT_W  = $clog2(NUM_PAGES + 1);
   localparam int SUM_W  = CNT_W + 2;
   localparam int RET_W  = FENCE_BITS + PAGE_W;
   localparam logic [SIZE_W-1:0] LIMIT_RESET = (PAGE_SIZE_RESET > MAX_PAGE_BYTES) ?
      SIZE_W'(MAX_PAGE_BYTES) : SIZE_W'(PAGE_SIZE_RESET);

   function automatic logic [PAGE_W-1:0] wrap_inc(input logic [PAGE_W-1:0] ptr);
      return (ptr == PAGE_W'(NUM_PAGES - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // Control state
   logic [SIZE_W-1:0] page_limit_ff, page_limit_in;
   logic              held_valid_ff, held_valid_in;
   logic [SIZE_W-1:0] fill_offset_ff, fill_offset_in;
   logic [CNT_W-1:0]  local_count_ff, local_count_in;
   logic [CNT_W-1:0]  loc_idx_ff, loc_idx_in;
   logic [PAGE_W-1:0] ret_head_ff, ret_head_in;
   logic [PAGE_W-1:0] ret_tail_ff, ret_tail_in;
   logic [CNT_W-1:0]  ret_count_ff, ret_count_in;
   logic [PAGE_W-1:0] free_head_ff, free_head_in;
   logic [PAGE_W-1:0] free_tail_ff, free_tail_in;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [CNT_W-1:0]  pages_made_ff, pages_made_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [PAGE_W-1:0]     held_page_ff, held_page_in;
   op_type                op_ff;
   logic [SIZE_W-1:0]     asize_ff;
   logic [WIDE_W-1:0]     aoff_ff;
   logic                  too_big_ff;
   logic [FENCE_BITS-1:0] fence_ff;
   logic [FENCE_BITS-1:0] done_ff;
   status_type            rsp_status_ff, rsp_status_in;
   logic [PAGE_IDX_W-1:0] rsp_page_ff, rsp_page_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [SIZE_W-1:0]     rsp_asize_ff, rsp_asize_in;
   logic                  rsp_took_ff, rsp_took_in;

   // Alignment of the incoming request
   logic [WIDE_W-1:0] amask;
   logic [WIDE_W-1:0] asize_w;
   logic [WIDE_W-1:0] aoff_w;
   logic [WIDE_W-1:0] end_w;
   logic              rsp_load;

   // Memory ports
   logic              loc_we;
   logic [PAGE_W-1:0] loc_rdata;
   logic              ret_we;
   logic [RET_W-1:0]  ret_rdata;
   logic              free_we;
   logic [PAGE_W-1:0] free_rdata;

   assign amask = (WIDE_W'(1) << req_tdata[IN_ALIGN_LSB +: ALIGN_W]) - WIDE_W'(1);
   assign asize_w = (WIDE_W'(req_tdata[IN_SIZE_LSB +: SIZE_W]) + amask) & ~amask;
   assign aoff_w  = (WIDE_W'(fill_offset_ff) + amask) & ~amask;
   assign end_w   = aoff_ff + WIDE_W'(asize_ff);

   // Status toward the controller
   assign stat.op_retire     = (op_ff == OP_RETIRE);
   assign stat.too_big       = too_big_ff;
   assign stat.fits          = held_valid_ff && (end_w <= WIDE_W'(page_limit_ff));
   assign stat.held_valid    = held_valid_ff;
   assign stat.ret_nonempty  = (ret_count_ff != '0);
   assign stat.fence_done    = (ret_rdata[PAGE_W +: FENCE_BITS] <= done_ff);
   assign stat.free_nonempty = (free_count_ff != '0);
   assign stat.can_make      = (pages_made_ff < CNT_W'(NUM_PAGES));
   assign stat.loc_more      = (loc_idx_ff < local_count_ff);
   assign stat.rsp_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_load = cmd.ok_held || cmd.take_free || cmd.take_new || cmd.no_page ||
                     cmd.too_big || cmd.retire_done;

   assign loc_we  = cmd.push_held && (local_count_ff < CNT_W'(NUM_PAGES));
   assign ret_we  = cmd.ret_push && (ret_count_ff < CNT_W'(NUM_PAGES));
   assign free_we = cmd.recycle && (free_count_ff < CNT_W'(NUM_PAGES));

   // Local list of pages filled since the last retire
   fpba_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_local_ram (
      .clock   (clock),
      .wr_en   (loc_we),
      .wr_addr (local_count_ff[PAGE_W-1:0]),
      .wr_data (held_page_ff),
      .rd_en   (cmd.loc_rd),
      .rd_addr (loc_idx_ff[PAGE_W-1:0]),
      .rd_data (loc_rdata)
   );

   // Retired queue: fence above page index
   fpba_ram #(.WIDTH(RET_W), .DEPTH(NUM_PAGES)) u_retired_ram (
      .clock   (clock),
      .wr_en   (ret_we),
      .wr_addr (ret_tail_ff),
      .wr_data ({fence_ff, loc_rdata}),
      .rd_en   (cmd.ret_rd),
      .rd_addr (ret_head_ff),
      .rd_data (ret_rdata)
   );

   // Free FIFO of recycled pages
   fpba_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_tail_ff),
      .wr_data (ret_rdata[PAGE_W-1:0]),
      .rd_en   (cmd.free_rd),
      .rd_addr (free_head_ff),
      .rd_data (free_rdata)
   );

   // Page limit from the configuration write, clamped to the maximum
   always_comb begin
      page_limit_in = page_limit_ff;
      if (csr_valid) begin
         page_limit_in = (WIDE_W'(csr_data) > WIDE_W'(MAX_PAGE_BYTES)) ?
                         SIZE_W'(MAX_PAGE_BYTES) : csr_data;
      end
   end

   // Held page, fill offset and list bookkeeping
   always_comb begin
      held_valid_in  = held_valid_ff;
      held_page_in   = held_page_ff;
      fill_offset_in = fill_offset_ff;
      local_count_in = local_count_ff;
      loc_idx_in     = loc_idx_ff;
      ret_head_in    = ret_head_ff;
      ret_tail_in    = ret_tail_ff;
      ret_count_in   = ret_count_ff;
      free_head_in   = free_head_ff;
      free_tail_in   = free_tail_ff;
      free_count_in  = free_count_ff;
      pages_made_in  = pages_made_ff;

      if (cmd.ok_held) begin
         fill_offset_in = end_w[SIZE_W-1:0];
      end
      if (cmd.push_held) begin
         held_valid_in = 1'b0;
         if (loc_we) begin
            local_count_in = local_count_ff + 1'b1;
         end
      end
      if (cmd.recycle) begin
         ret_head_in  = wrap_inc(ret_head_ff);
         ret_count_in = ret_count_ff - 1'b1;
         if (free_we) begin
            free_tail_in  = wrap_inc(free_tail_ff);
            free_count_in = free_count_ff + 1'b1;
         end
      end
      if (cmd.take_free) begin
         held_valid_in  = 1'b1;
         held_page_in   = free_rdata;
         fill_offset_in = asize_ff;
         free_head_in   = wrap_inc(free_head_ff);
         free_count_in  = free_count_ff - 1'b1;
      end
      if (cmd.take_new) begin
         held_valid_in  = 1'b1;
         held_page_in   = pages_made_ff[PAGE_W-1:0];
         fill_offset_in = asize_ff;
         pages_made_in  = pages_made_ff + 1'b1;
      end
      if (cmd.no_page) begin
         fill_offset_in = '0;
      end
      if (cmd.ret_push) begin
         loc_idx_in = loc_idx_ff + 1'b1;
         if (ret_we) begin
            ret_tail_in  = wrap_inc(ret_tail_ff);
            ret_count_in = ret_count_ff + 1'b1;
         end
      end
      if (cmd.retire_done) begin
         held_valid_in  = 1'b0;
         fill_offset_in = '0;
         local_count_in = '0;
         loc_idx_in     = '0;
      end
   end

   // Result fields for each kind of answer
   always_comb begin
      rsp_status_in = STATUS_OK;
      rsp_page_in   = '0;
      rsp_offset_in = '0;
      rsp_asize_in  = '0;
      rsp_took_in   = 1'b0;
      priority if (cmd.ok_held) begin
         rsp_page_in   = PAGE_IDX_W'(held_page_ff);
         rsp_offset_in = aoff_ff[OFFSET_W-1:0];
         rsp_asize_in  = asize_ff;
      end else if (cmd.take_free) begin
         rsp_page_in  = PAGE_IDX_W'(free_rdata);
         rsp_asize_in = asize_ff;
         rsp_took_in  = 1'b1;
      end else if (cmd.take_new) begin
         rsp_page_in  = PAGE_IDX_W'(pages_made_ff[PAGE_W-1:0]);
         rsp_asize_in = asize_ff;
         rsp_took_in  = 1'b1;
      end else if (cmd.no_page) begin
         rsp_status_in = STATUS_NO_PAGE;
         rsp_asize_in  = asize_ff;
      end else if (cmd.too_big) begin
         rsp_status_in = STATUS_TOO_BIG;
         rsp_asize_in  = '1;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_limit_ff  <= LIMIT_RESET;
         held_valid_ff  <= 1'b0;
         fill_offset_ff <= '0;
         local_count_ff <= '0;
         loc_idx_ff     <= '0;
         ret_head_ff    <= '0;
         ret_tail_ff    <= '0;
         ret_count_ff   <= '0;
         free_head_ff   <= '0;
         free_tail_ff   <= '0;
         free_count_ff  <= '0;
         pages_made_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         page_limit_ff  <= page_limit_in;
         held_valid_ff  <= held_valid_in;
         fill_offset_ff <= fill_offset_in;
         local_count_ff <= local_count_in;
         loc_idx_ff     <= loc_idx_in;
         ret_head_ff    <= ret_head_in;
         ret_tail_ff    <= ret_tail_in;
         ret_count_ff   <= ret_count_in;
         free_head_ff   <= free_head_in;
         free_tail_ff   <= free_tail_in;
         free_count_ff  <= free_count_in;
         pages_made_ff  <= pages_made_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      held_page_ff <= held_page_in;
      if (cmd.accept) begin
         op_ff      <= op_type'(req_tuser);
         asize_ff   <= asize_w[SIZE_W-1:0];
         too_big_ff <= (asize_w > WIDE_W'(page_limit_ff));
         aoff_ff    <= aoff_w;
         fence_ff   <= req_tdata[IN_FENCE_LSB +: FENCE_BITS];
         done_ff    <= req_tdata[IN_DONE_LSB +: FENCE_BITS];
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_page_ff   <= rsp_page_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_asize_ff  <= rsp_asize_in;
         rsp_took_ff   <= rsp_took_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_took_ff, rsp_asize_ff, rsp_offset_ff, rsp_page_ff});

`ifndef SYNTHESIS
   // Pages outside the local list never outnumber the pages made
   a_page_conservation: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(free_count_ff) + SUM_W'(ret_count_ff) + SUM_W'(held_valid_ff)
         <= SUM_W'(pages_made_ff))
      else $error("more pages in queues than were made");

   // A new answer never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // Page creation only counts up
   a_made_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (pages_made_ff >= $past(pages_made_ff)))
      else $error("pages_made decreased");

   // Taking a page leaves it held
   a_take_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_free || cmd.take_new) |=> held_valid_ff)
      else $error("page taken but not held");
`endif

endmodule
